### hdl/pdr_pkg.sv
// Shared types, constants and helpers for the packed decimal rescale block.
`timescale 1ns / 1ps

package pdr_pkg;

  // Largest digit count of a packed field; larger counts saturate here
  localparam logic [4:0] FIELD_DIGITS_MAX = 5'd18;

  // Depth of the beat queue between front and back
  localparam int QDEPTH = 2;

  // Sign nibbles
  localparam logic [3:0] SIGN_PLUS      = 4'hC;
  localparam logic [3:0] SIGN_MINUS     = 4'hD;
  localparam logic [3:0] SIGN_MINUS_ALT = 4'hB;
  localparam logic [3:0] SIGN_UNSIGNED  = 4'hF;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_SRC_DIGITS = 3'd0,
    REG_SRC_SCALE  = 3'd1,
    REG_SRC_SIGNED = 3'd2,
    REG_DST_DIGITS = 3'd3,
    REG_DST_SCALE  = 3'd4,
    REG_DST_SIGNED = 3'd5
  } cfg_reg_e;

  // Back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LO,
    BK_RD,
    BK_FLUSH
  } back_state_e;

  // Current configuration
  typedef struct packed {
    logic [4:0] src_digits;
    logic [6:0] src_scale;
    logic       src_signed;
    logic [4:0] dst_digits;
    logic [6:0] dst_scale;
    logic       dst_signed;
  } cfg_t;

  // One classified source byte
  typedef struct packed {
    logic [7:0] data;
    logic [3:0] index;
    logic       last;
    logic       neg;
  } src_beat_t;

  function automatic logic [4:0] sat_digits(input logic [4:0] d);
    return (d > FIELD_DIGITS_MAX) ? FIELD_DIGITS_MAX : d;
  endfunction

endpackage

### hdl/packed_decimal_rescale_core.sv
// Top level of the packed decimal rescale block: configuration registers and front/back wiring.
`timescale 1ns / 1ps

// Usage:
//   Source bytes of a packed decimal field enter on src_byte_i, most significant
//   first; a byte is taken at a clock edge with start_i high and busy_o low.
//   Configuration registers are written over cfg_valid_i/cfg_index_i/cfg_data_i;
//   cfg_ready_o is always high. Write them only while the block is idle.
//   A two-beat queue holds accepted bytes, so busy_o rises only when it is full.
//   In the back end each source byte is written in BK_IDLE, then in BK_LO: the
//   window memory has one write port and each byte carries two digit nibbles.
//   After the last source byte of a field the back end reads the window one
//   nibble a cycle, giving sat_digits(dst_digits)/2+1 result bytes; the state
//   BK_FLUSH then clears the window.
//   A result beat is shown on dst_byte_o/last_byte_o for one cycle with
//   dst_strobe_o high; the receiver cannot stall and must take it then.
//   Reset clears the queue, the byte count, the window and restores the
//   configuration defaults (18 digits, scale 0, signed, for both sides).
module packed_decimal_rescale_core
  import pdr_pkg::*;
#(
  parameter int HALF_DIGITS = 18
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [7:0] src_byte_i,
  output logic       dst_strobe_o,
  output logic [7:0] dst_byte_o,
  output logic       last_byte_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [6:0] cfg_data_i
);

  cfg_t      cfg_q, cfg_d;
  src_beat_t push_beat;
  src_beat_t head_beat;
  logic      push;
  logic      pop;
  logic      q_empty;
  logic      q_full;

  assign cfg_ready_o = 1'b1;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_SRC_DIGITS: cfg_d.src_digits = cfg_data_i[4:0];
        REG_SRC_SCALE:  cfg_d.src_scale  = cfg_data_i;
        REG_SRC_SIGNED: cfg_d.src_signed = cfg_data_i[0];
        REG_DST_DIGITS: cfg_d.dst_digits = cfg_data_i[4:0];
        REG_DST_SCALE:  cfg_d.dst_scale  = cfg_data_i;
        REG_DST_SIGNED: cfg_d.dst_signed = cfg_data_i[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_digits <= FIELD_DIGITS_MAX;
      cfg_q.src_scale  <= 7'd0;
      cfg_q.src_signed <= 1'b1;
      cfg_q.dst_digits <= FIELD_DIGITS_MAX;
      cfg_q.dst_scale  <= 7'd0;
      cfg_q.dst_signed <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  pdr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .src_byte_i (src_byte_i),
    .cfg_i      (cfg_q),
    .q_full_i   (q_full),
    .busy_o     (busy_o),
    .push_o     (push),
    .beat_o     (push_beat)
  );

  pdr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .beat_i  (push_beat),
    .pop_i   (pop),
    .head_o  (head_beat),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  pdr_back #(
    .HALF_DIGITS (HALF_DIGITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_i       (head_beat),
    .empty_i      (q_empty),
    .pop_o        (pop),
    .dst_strobe_o (dst_strobe_o),
    .dst_byte_o   (dst_byte_o),
    .last_byte_o  (last_byte_o)
  );

endmodule

### hdl/pdr_front.sv
// Front end: accepts source bytes, tracks the field position and marks the last byte.
`timescale 1ns / 1ps

module pdr_front
  import pdr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic [7:0] src_byte_i,
  input  cfg_t      cfg_i,
  input  logic      q_full_i,
  output logic      busy_o,
  output logic      push_o,
  output src_beat_t beat_o
);

  logic [3:0] taken_q, taken_d;
  logic [4:0] sd;
  logic [4:0] snb;
  logic       is_last;
  logic       is_neg;

  // Source field size from the current digit count
  assign sd      = sat_digits(cfg_i.src_digits);
  assign snb     = {1'b0, sd[4:1]} + 5'd1;
  assign is_last = ({1'b0, taken_q} + 5'd1) >= snb;

  // Only the low nibble of the last byte carries the sign
  assign is_neg = cfg_i.src_signed &&
                  ((src_byte_i[3:0] == SIGN_MINUS) || (src_byte_i[3:0] == SIGN_MINUS_ALT));

  assign busy_o = q_full_i;
  assign push_o = start_i && !q_full_i;

  always_comb begin
    beat_o.data  = src_byte_i;
    beat_o.index = taken_q;
    beat_o.last  = is_last;
    beat_o.neg   = is_neg;
  end

  // Advance the byte count, restart after the last byte
  always_comb begin
    taken_d = taken_q;
    if (push_o) begin
      taken_d = is_last ? 4'd0 : taken_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q <= 4'd0;
    end else begin
      taken_q <= taken_d;
    end
  end

endmodule

### hdl/pdr_queue.sv
// Short beat queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module pdr_queue
  import pdr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  src_beat_t beat_i,
  input  logic      pop_i,
  output src_beat_t head_o,
  output logic      empty_o,
  output logic      full_o
);

  localparam int QAW = $clog2(QDEPTH);

  src_beat_t      slot_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QAW:0]   count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (QAW+1)'(QDEPTH));
  assign head_o  = slot_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + QAW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + QAW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + (QAW+1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= beat_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("queue pushed while full");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("queue popped while empty");

endmodule

### hdl/pdr_back.sv
// Back end: places digits into the window memory and reads out the destination field.
`timescale 1ns / 1ps

module pdr_back
  import pdr_pkg::*;
#(
  parameter int HALF_DIGITS = 18
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  src_beat_t  head_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       dst_strobe_o,
  output logic [7:0] dst_byte_o,
  output logic       last_byte_o
);

  localparam int WIN = 2 * HALF_DIGITS;
  localparam int AW  = $clog2(WIN);
  localparam int PW  = $clog2(HALF_DIGITS + 56) + 1;

  back_state_e state_q, state_d;
  src_beat_t   cur_q, cur_d;
  logic [4:0]  n_q, n_d;
  logic [WIN-1:0] valid_q, valid_d;

  logic       s2_vld_q, s2_vld_d;
  logic       s2_odd_q, s2_odd_d;
  logic       s2_last_q, s2_last_d;
  logic       s2_ok_q, s2_ok_d;
  logic [3:0] hi_q;
  logic [3:0] rdata_q;

  logic [3:0] win_mem [WIN];

  logic [4:0] sd, dd;
  logic       soff, doff;
  logic [4:0] last_n;
  logic signed [PW-1:0] sbase, dbase;

  logic [4:0] pl_pos;
  logic       pl_off;
  logic [4:0] pl_nd;
  logic signed [PW-1:0] pl_base, pl_i, pl_w;
  logic       pl_ok;
  logic [AW-1:0] pl_addr;

  logic       mem_we, mem_re;
  logic [3:0] wr_nib;
  logic [3:0] nib;
  logic [3:0] sign_nib;

  // Field geometry from the current configuration
  assign sd     = sat_digits(cfg_i.src_digits);
  assign dd     = sat_digits(cfg_i.dst_digits);
  assign soff   = ~sd[0];
  assign doff   = ~dd[0];
  assign last_n = {dd[4:1], 1'b1};
  assign sbase  = $signed(PW'(HALF_DIGITS)) - $signed(PW'(sd))
                + $signed(PW'($signed(cfg_i.src_scale)));
  assign dbase  = $signed(PW'(HALF_DIGITS)) - $signed(PW'(dd))
                + $signed(PW'($signed(cfg_i.dst_scale)));

  // Shared placement unit: nibble position to window address
  always_comb begin
    pl_i    = $signed(PW'(pl_pos)) - $signed(PW'(pl_off));
    pl_w    = pl_base + pl_i;
    pl_ok   = !pl_i[PW-1] && (pl_i < $signed(PW'(pl_nd))) &&
              !pl_w[PW-1] && (pl_w < $signed(PW'(WIN)));
    pl_addr = pl_w[AW-1:0];
  end

  // Sequencer: write high nibble, write low nibble, read out on the last byte, then clear the window
  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    n_d       = n_q;
    valid_d   = valid_q;
    pop_o     = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    wr_nib    = cur_q.data[3:0];
    pl_pos    = {cur_q.index, 1'b1};
    pl_off    = soff;
    pl_nd     = sd;
    pl_base   = sbase;
    s2_vld_d  = 1'b0;
    s2_odd_d  = n_q[0];
    s2_last_d = (n_q == last_n);
    s2_ok_d   = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        pl_pos = {head_i.index, 1'b0};
        wr_nib = head_i.data[7:4];
        if (!empty_i) begin
          pop_o   = 1'b1;
          mem_we  = pl_ok;
          cur_d   = head_i;
          state_d = BK_LO;
        end
      end
      BK_LO: begin
        mem_we = pl_ok;
        if (cur_q.last) begin
          n_d     = 5'd0;
          state_d = BK_RD;
        end else begin
          state_d = BK_IDLE;
        end
      end
      BK_RD: begin
        pl_pos   = n_q;
        pl_off   = doff;
        pl_nd    = dd;
        pl_base  = dbase;
        mem_re   = 1'b1;
        s2_vld_d = 1'b1;
        s2_ok_d  = pl_ok && valid_q[pl_addr];
        if (n_q == last_n) begin
          state_d = BK_FLUSH;
        end else begin
          n_d = n_q + 5'd1;
        end
      end
      BK_FLUSH: begin
        // Drop the window contents for the next field
        valid_d = '0;
        state_d = BK_IDLE;
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
    if (mem_we) begin
      valid_d[pl_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      n_q       <= 5'd0;
      valid_q   <= '0;
      s2_vld_q  <= 1'b0;
      s2_odd_q  <= 1'b0;
      s2_last_q <= 1'b0;
      s2_ok_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      n_q       <= n_d;
      valid_q   <= valid_d;
      s2_vld_q  <= s2_vld_d;
      s2_odd_q  <= s2_odd_d;
      s2_last_q <= s2_last_d;
      s2_ok_q   <= s2_ok_d;
    end
  end

  // Window memory with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      win_mem[pl_addr] <= wr_nib;
    end
    if (mem_re) begin
      rdata_q <= win_mem[pl_addr];
    end
  end

  // Hold the current beat and the high nibble of the byte being built
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (s2_vld_q && !s2_odd_q) begin
      hi_q <= nib;
    end
  end

  // Assemble the destination byte
  assign nib      = s2_ok_q ? rdata_q : 4'h0;
  assign sign_nib = cfg_i.dst_signed ? (cur_q.neg ? SIGN_MINUS : SIGN_PLUS) : SIGN_UNSIGNED;

  assign dst_strobe_o = s2_vld_q && s2_odd_q;
  assign dst_byte_o   = {hi_q, s2_last_q ? sign_nib : nib};
  assign last_byte_o  = s2_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dst_strobe_o |-> (state_q == BK_RD) || (state_q == BK_FLUSH))
    else $error("result beat outside readout");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == BK_IDLE) || (state_q == BK_LO))
    else $error("window write during readout");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_FLUSH) |=> (valid_q == '0))
    else $error("window not cleared after field");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dst_strobe_o && last_byte_o) |-> (state_q == BK_FLUSH))
    else $error("last byte not at end of readout");

endmodule

### tb/pdr_move_checker.sv
// Checker for the packed decimal rescale block: predicts destination beats and compares them.
`timescale 1ns / 1ps

module pdr_move_checker
  import pdr_pkg::*;
#(
  parameter int HALF_DIGITS = 18
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       busy_i,
  input  logic [7:0] src_byte_i,
  input  logic       dst_strobe_i,
  input  logic [7:0] dst_byte_i,
  input  logic       last_byte_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [2:0] cfg_index_i,
  input  logic [6:0] cfg_data_i,
  output int         fail_cnt_o,
  output int         due_cnt_o,
  output int         checked_cnt_o
);

  localparam int WIN_DIGITS = 2 * HALF_DIGITS;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } dst_beat_t;

  // Shadow of the block: registers, digit window, byte count, sign
  cfg_t       cfg_q;
  logic [3:0] win_q [WIN_DIGITS];
  logic [3:0] taken_q;
  logic       neg_q;

  // Destination beats still due, oldest first
  dst_beat_t  due_q [$];
  dst_beat_t  head;
  int         fail_cnt;
  int         checked_cnt;

  function automatic int clamp_digits(input logic [4:0] d);
    return (d > FIELD_DIGITS_MAX) ? int'(FIELD_DIGITS_MAX) : int'(d);
  endfunction

  // Drop a source nibble into the window unless it falls outside
  task automatic place_nibble(input int pos, input int off, input int nd, input int base,
                              input logic [3:0] nib);
    int i;
    int w;
    i = pos - off;
    w = base + i;
    if (i >= 0 && i < nd && w >= 0 && w < WIN_DIGITS) begin
      win_q[w] = nib;
    end
  endtask

  // Read a destination nibble; outside the field or window it is zero
  function automatic logic [3:0] fetch_nibble(input int pos, input int off, input int nd,
                                              input int base);
    int i;
    int w;
    i = pos - off;
    w = base + i;
    if (i < 0 || i >= nd || w < 0 || w >= WIN_DIGITS) begin
      return 4'h0;
    end
    return win_q[w];
  endfunction

  task automatic clear_window();
    for (int w = 0; w < WIN_DIGITS; w++) begin
      win_q[w] = 4'h0;
    end
  endtask

  task automatic apply_write(input logic [2:0] idx, input logic [6:0] data);
    case (cfg_reg_e'(idx))
      REG_SRC_DIGITS: cfg_q.src_digits = data[4:0];
      REG_SRC_SCALE:  cfg_q.src_scale  = data;
      REG_SRC_SIGNED: cfg_q.src_signed = data[0];
      REG_DST_DIGITS: cfg_q.dst_digits = data[4:0];
      REG_DST_SCALE:  cfg_q.dst_scale  = data;
      REG_DST_SIGNED: cfg_q.dst_signed = data[0];
      default: ;
    endcase
  endtask

  // Take one source byte; on the last byte of a field queue the rescaled field
  task automatic absorb_byte(input logic [7:0] b);
    int         sd, snb, soff, sbase;
    int         dd, dnb, doff, dbase;
    logic [3:0] sign;
    logic [3:0] hi;
    logic [3:0] lo;
    dst_beat_t  beat;
    sd    = clamp_digits(cfg_q.src_digits);
    snb   = sd / 2 + 1;
    soff  = (sd % 2 == 1) ? 0 : 1;
    sbase = HALF_DIGITS - sd + int'($signed(cfg_q.src_scale));
    place_nibble(2 * int'(taken_q), soff, sd, sbase, b[7:4]);
    place_nibble(2 * int'(taken_q) + 1, soff, sd, sbase, b[3:0]);
    if (int'(taken_q) < snb - 1) begin
      taken_q = taken_q + 4'd1;
    end else begin
      neg_q = cfg_q.src_signed && (b[3:0] == SIGN_MINUS || b[3:0] == SIGN_MINUS_ALT);
      if (cfg_q.dst_signed) begin
        sign = neg_q ? SIGN_MINUS : SIGN_PLUS;
      end else begin
        sign = SIGN_UNSIGNED;
      end
      dd    = clamp_digits(cfg_q.dst_digits);
      dnb   = dd / 2 + 1;
      doff  = (dd % 2 == 1) ? 0 : 1;
      dbase = HALF_DIGITS - dd + int'($signed(cfg_q.dst_scale));
      for (int k = 0; k < dnb; k++) begin
        hi = fetch_nibble(2 * k, doff, dd, dbase);
        lo = fetch_nibble(2 * k + 1, doff, dd, dbase);
        if (k == dnb - 1) begin
          lo = lo | sign;
        end
        beat.data = {hi, lo};
        beat.last = (k == dnb - 1);
        due_q.push_back(beat);
      end
      clear_window();
      taken_q = 4'd0;
    end
  endtask

  // Compare result beats, then follow register writes and source beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_digits = 5'd18;
      cfg_q.src_scale  = 7'd0;
      cfg_q.src_signed = 1'b1;
      cfg_q.dst_digits = 5'd18;
      cfg_q.dst_scale  = 7'd0;
      cfg_q.dst_signed = 1'b1;
      clear_window();
      taken_q     = 4'd0;
      neg_q       = 1'b0;
      fail_cnt    = 0;
      checked_cnt = 0;
      due_q.delete();
      fail_cnt_o    <= 0;
      due_cnt_o     <= 0;
      checked_cnt_o <= 0;
    end else begin
      if (dst_strobe_i) begin
        if (due_q.size() == 0) begin
          $error("dst_byte: no beat due, actual %02h", dst_byte_i);
          fail_cnt++;
        end else begin
          head = due_q.pop_front();
          if (dst_byte_i !== head.data) begin
            $error("dst_byte: expected %02h, actual %02h", head.data, dst_byte_i);
            fail_cnt++;
          end
          if (last_byte_i !== head.last) begin
            $error("last_byte: expected %0b, actual %0b", head.last, last_byte_i);
            fail_cnt++;
          end
          checked_cnt++;
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        apply_write(cfg_index_i, cfg_data_i);
      end
      if (start_i && !busy_i) begin
        absorb_byte(src_byte_i);
      end
      fail_cnt_o    <= fail_cnt;
      due_cnt_o     <= due_q.size();
      checked_cnt_o <= checked_cnt;
    end
  end

endmodule

### tb/packed_decimal_rescale_core_tb.sv
// Testbench top for the packed decimal rescale block: reset, stimulus and verdict.
`timescale 1ns / 1ps

module packed_decimal_rescale_core_tb;
  import pdr_pkg::*;

  localparam int HALF          = 18;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 2000;
  localparam int BYTE_TARGET   = 320;
  localparam int QUIET_FROM    = 270;

  logic       clk_i;
  logic       rst_ni;
  logic       start_i;
  logic       busy_o;
  logic [7:0] src_byte_i;
  logic       dst_strobe_o;
  logic [7:0] dst_byte_o;
  logic       last_byte_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [2:0] cfg_index_i;
  logic [6:0] cfg_data_i;

  int fail_cnt;
  int due_cnt;
  int checked_cnt;
  int bytes_sent    = 0;
  int settings_used = 0;
  int stall_cycles  = 0;

  logic [4:0] src_digits_now;
  logic [6:0] src_scale_now;

  packed_decimal_rescale_core #(
    .HALF_DIGITS(HALF)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .src_byte_i  (src_byte_i),
    .dst_strobe_o(dst_strobe_o),
    .dst_byte_o  (dst_byte_o),
    .last_byte_o (last_byte_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  pdr_move_checker #(
    .HALF_DIGITS(HALF)
  ) chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .src_byte_i   (src_byte_i),
    .dst_strobe_i (dst_strobe_o),
    .dst_byte_i   (dst_byte_o),
    .last_byte_i  (last_byte_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_cnt_o   (fail_cnt),
    .due_cnt_o    (due_cnt),
    .checked_cnt_o(checked_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stop the run when no beat of any kind moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || dst_strobe_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Offer one source beat and hold it until the block takes it
  task automatic push_byte(input logic [7:0] b);
    start_i    <= 1'b1;
    src_byte_i <= b;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // Send a source beat, then optionally drop start for a burst of idle cycles
  task automatic feed(input logic [7:0] b, input int gap);
    push_byte(b);
    bytes_sent++;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic stop_feed();
    start_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait for every due beat, then let the back end finish its clearing pass
  task automatic settle();
    while (due_cnt != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [6:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_SRC_DIGITS) src_digits_now = d[4:0];
    if (idx == REG_SRC_SCALE) src_scale_now = d;
  endtask

  task automatic end_writes();
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    settings_used++;
  endtask

  function automatic logic [3:0] rand_digit();
    if ($urandom_range(0, 9) == 0) return 4'($urandom_range(0, 15));
    return 4'($urandom_range(0, 9));
  endfunction

  function automatic logic [3:0] rand_sign();
    case ($urandom_range(0, 5))
      0: return SIGN_PLUS;
      1: return SIGN_MINUS;
      2: return SIGN_MINUS_ALT;
      3: return SIGN_UNSIGNED;
      default: return 4'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic logic [6:0] rand_digits_data();
    if ($urandom_range(0, 9) == 0) return 7'($urandom_range(0, 127));
    return 7'($urandom_range(1, 18));
  endfunction

  function automatic logic [6:0] rand_scale_data();
    if ($urandom_range(0, 4) == 0) return 7'($urandom_range(0, 127));
    return 7'(int'($urandom_range(0, 54)) - 18);
  endfunction

  function automatic logic [6:0] rand_flag_data();
    if ($urandom_range(0, 7) == 0) return 7'($urandom_range(0, 127));
    return 7'($urandom_range(0, 1));
  endfunction

  function automatic int pick_gap(input bit bursty);
    if (!bursty || bytes_sent >= QUIET_FROM) return 0;
    if ($urandom_range(0, 4) == 0) return int'($urandom_range(1, 18));
    return 0;
  endfunction

  // Rewrite a random subset of the registers; the destination scale often tracks the source
  task automatic pick_settings();
    if ($urandom_range(0, 3) != 0) write_reg(REG_SRC_DIGITS, rand_digits_data());
    if ($urandom_range(0, 3) != 0) write_reg(REG_SRC_SCALE, rand_scale_data());
    if ($urandom_range(0, 3) != 0) write_reg(REG_SRC_SIGNED, rand_flag_data());
    if ($urandom_range(0, 3) != 0) write_reg(REG_DST_DIGITS, rand_digits_data());
    if ($urandom_range(0, 1) == 0) begin
      write_reg(REG_DST_SCALE, 7'(int'(src_scale_now) + int'($urandom_range(0, 6)) - 3));
    end else begin
      write_reg(REG_DST_SCALE, rand_scale_data());
    end
    if ($urandom_range(0, 3) != 0) write_reg(REG_DST_SIGNED, rand_flag_data());
    end_writes();
  endtask

  initial begin
    logic [7:0] dflt_field [10];
    logic [7:0] b;
    logic [3:0] hi;
    logic [3:0] lo;
    int         nd;
    int         nbytes;
    int         nfields;
    bit         bursty;
    bit         tidy;

    dflt_field = '{8'h01, 8'h23, 8'h45, 8'h67, 8'h89, 8'h98, 8'h76, 8'h54, 8'h32, 8'h1D};
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    src_byte_i     = 8'h00;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = REG_SRC_DIGITS;
    cfg_data_i     = 7'd0;
    src_digits_now = 5'd18;
    src_scale_now  = 7'd0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Full 18 digit negative field at the reset settings
    for (int j = 0; j < 10; j++) begin
      feed(dflt_field[j], 0);
    end
    stop_feed();
    settle();

    // Zero digit count: a single byte holding pad and sign on both sides
    write_reg(REG_SRC_DIGITS, 7'd0);
    write_reg(REG_DST_DIGITS, 7'd0);
    end_writes();
    feed({4'h0, SIGN_MINUS_ALT}, 0);
    stop_feed();
    settle();

    // Scale extremes and a saturating destination digit count
    write_reg(REG_SRC_DIGITS, 7'd1);
    write_reg(REG_SRC_SCALE, 7'h40);
    write_reg(REG_DST_DIGITS, 7'h1F);
    write_reg(REG_DST_SCALE, 7'h3F);
    end_writes();
    feed({4'h9, SIGN_PLUS}, 0);
    stop_feed();
    settle();

    // Unsigned on both sides, non-decimal digit nibbles, all-zero and all-one bytes
    write_reg(REG_SRC_DIGITS, 7'd3);
    write_reg(REG_SRC_SCALE, 7'd0);
    write_reg(REG_SRC_SIGNED, 7'd0);
    write_reg(REG_DST_DIGITS, 7'd3);
    write_reg(REG_DST_SCALE, 7'd0);
    write_reg(REG_DST_SIGNED, 7'd0);
    end_writes();
    feed(8'hFA, 0);
    feed(8'hBD, 0);
    feed(8'h00, 3);
    feed(8'h00, 3);
    feed(8'hFF, 3);
    feed(8'hFF, 0);
    stop_feed();
    settle();

    // Shrink the source digit count in the middle of a field
    write_reg(REG_SRC_DIGITS, 7'd5);
    write_reg(REG_SRC_SIGNED, 7'd1);
    write_reg(REG_DST_SIGNED, 7'd1);
    end_writes();
    feed(8'h12, 0);
    stop_feed();
    settle();
    write_reg(REG_SRC_DIGITS, 7'd2);
    end_writes();
    feed({4'h3, SIGN_PLUS}, 0);
    stop_feed();
    settle();

    // Random phases: new settings, then whole fields, mostly well-formed
    while (bytes_sent < BYTE_TARGET) begin
      pick_settings();
      bursty  = ($urandom_range(0, 2) != 0);
      nfields = int'($urandom_range(1, 4));
      nd      = (src_digits_now > FIELD_DIGITS_MAX) ? int'(FIELD_DIGITS_MAX)
                                                    : int'(src_digits_now);
      nbytes  = nd / 2 + 1;
      for (int f = 0; f < nfields; f++) begin
        tidy = ($urandom_range(0, 6) != 0);
        for (int j = 0; j < nbytes; j++) begin
          if (tidy) begin
            hi = rand_digit();
            lo = (j == nbytes - 1) ? rand_sign() : rand_digit();
            b  = {hi, lo};
          end else begin
            b = 8'($urandom_range(0, 255));
          end
          feed(b, pick_gap(bursty));
        end
      end
      stop_feed();
      settle();
    end

    $display("Sent %0d source bytes under %0d register settings; %0d destination bytes checked.",
             bytes_sent, settings_used, checked_cnt);
    if (fail_cnt == 0 && due_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
hdl/pdr_pkg.sv
hdl/pdr_front.sv
hdl/pdr_queue.sv
hdl/pdr_back.sv
hdl/packed_decimal_rescale_core.sv
tb/pdr_move_checker.sv
tb/packed_decimal_rescale_core_tb.sv
